FILE: src/ddoh_pkg.sv
// Shared types and constants of the differential-drive odometry integrator.
// Depends on nothing; the multiplier, the CORDIC and the top level import it.
package ddoh_pkg;

	localparam int MUL_A_W = 64;
	localparam int MUL_B_W = 35;
	localparam int MUL_N_W = 6;
	localparam int CORD_W  = 34;
	localparam int ATAN_N  = 24;

	localparam logic [30:0] TURN_PER_RAD = 31'd683565276;
	localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [MUL_N_W-1:0] N_SHORT = 6'd17;
	localparam logic [MUL_N_W-1:0] N_TURN  = 6'd31;

	localparam logic [0:0] REG_STEP_TIME = 1'b0;
	localparam logic [0:0] REG_INV_TRACK = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_W_OLD, ST_W_NEW, ST_P1, ST_D1, ST_COS0, ST_COS1,
		ST_MX0, ST_MX1, ST_MY0, ST_MY1, ST_DX, ST_DY, ST_HS, ST_HD, ST_FIN
	} st_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;  5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;  5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;  5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;  5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

FILE: src/ddoh_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on ddoh_pkg.
module ddoh_mul
	import ddoh_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [MUL_A_W-1:0]  a,
	input  logic        [MUL_B_W-1:0]  b,
	input  logic        [MUL_N_W-1:0]  nbits,
	output logic                       done,
	output logic signed [MUL_A_W-1:0]  prod
);

	logic signed [MUL_A_W-1:0] acc_q, a_q;
	logic        [MUL_B_W-1:0] b_q;
	logic        [MUL_N_W-1:0] cnt_q, n_q;
	logic                      busy_q, done_q;
	logic signed [MUL_A_W-1:0] pp;
	logic                      last;

	assign pp   = b_q[0] ? a_q : '0;
	// The top bit of the multiplier carries negative weight.
	assign last = (cnt_q == n_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
			n_q   <= nbits;
		end else if (busy_q) begin
			acc_q <= last ? acc_q - pp : acc_q + pp;
			a_q   <= a_q <<< 1;
			b_q   <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

FILE: src/ddoh_cordic.sv
// Iterative CORDIC rotation giving cosine and sine of a 32-bit turn angle.
// Depends on ddoh_pkg.
module ddoh_cordic
	import ddoh_pkg::*;
#(
	parameter int ITERS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic        [31:0]       theta,
	output logic                     done,
	output logic signed [CORD_W-1:0] cos_o,
	output logic signed [CORD_W-1:0] sin_o
);

	localparam int NIT = (ITERS < ATAN_N) ? ITERS : ATAN_N;
	localparam logic [4:0] LAST_IT = 5'(NIT - 1);

	logic signed [CORD_W-1:0] x_q, y_q, xs, ys;
	logic signed [32:0]       z_q, at;
	logic        [1:0]        q_q, q;
	logic        [31:0]       ru;
	logic        [4:0]        it_q;
	logic                     busy_q, done_q;

	assign q  = 2'((theta + 32'h20000000) >> 30);
	assign ru = theta - {q, 30'd0};
	assign xs = x_q >>> it_q;
	assign ys = y_q >>> it_q;
	assign at = $signed({1'b0, atan_turn(it_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				it_q   <= '0;
			end else if (busy_q) begin
				it_q <= it_q + 1'b1;
				if (it_q == LAST_IT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= $signed({ru[31], ru});
			q_q <= q;
		end else if (busy_q) begin
			if (!z_q[32]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	always_comb begin
		unique case (q_q)
			2'd0: begin cos_o = x_q;  sin_o = y_q;  end
			2'd1: begin cos_o = -y_q; sin_o = x_q;  end
			2'd2: begin cos_o = -x_q; sin_o = -y_q; end
			default: begin cos_o = y_q; sin_o = -x_q; end
		endcase
	end

	assign done = done_q;

endmodule

FILE: src/diff_drive_odometry_heun.sv
// Differential-drive odometry, one Heun step per transfer, fixed point throughout.
// A load or an error result goes from the FIN state into the output register; an integrate
// result first takes ten 17-bit serial multiplies, two 31-bit ones and two CORDIC runs.
// Throughput: one item at a time; the next input transfer is taken the cycle after the result
// enters the output register. Reset clears the pose, the registers to their defaults, all control.
module diff_drive_odometry_heun
	import ddoh_pkg::*;
#(
	parameter int SINCOS_ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic signed [15:0] right_prev,
	input  logic signed [15:0] left_prev,
	input  logic signed [15:0] right_new,
	input  logic signed [15:0] left_new,
	input  logic signed [31:0] load_x,
	input  logic signed [31:0] load_y,
	input  logic        [15:0] load_heading,
	// output channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic        [15:0] out_heading,
	output logic               config_error
);

	st_t state_q, state_d;

	logic [15:0] step_time_q, itw_q;
	logic signed [15:0] ro_q, lo_q, rn_q, ln_q;
	logic [31:0] x_q, y_q, th1_q;
	logic [15:0] h_q;
	logic        err_q, issued_q;
	logic signed [33:0] w_old_q, w_new_q;
	logic signed [CORD_W-1:0] c0_q, s0_q, c1_q, s1_q;
	logic signed [63:0] t_q, sx_q, sy_q;
	logic        out_valid_q, out_err_q;
	logic [31:0] out_x_q, out_y_q;
	logic [15:0] out_h_q;

	logic        mul_start, mul_done, cord_start, cord_done;
	logic signed [MUL_A_W-1:0] mul_a, prod;
	logic        [MUL_B_W-1:0] mul_b;
	logic        [MUL_N_W-1:0] mul_n;
	logic [31:0] cord_th;
	logic signed [CORD_W-1:0] cord_c, cord_s;
	logic        is_cord, op_done, in_xfer, fin_go;
	logic signed [16:0] v_old, v_new, d_old, d_new;
	logic signed [63:0] r16, r17, r_th1, r_pos, r_h;

	// The configuration port has no wait states; a write lands in the access cycle.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_time_q <= 16'd655;
			itw_q       <= 16'd0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_STEP_TIME: step_time_q <= pwdata[15:0];
				REG_INV_TRACK: itw_q       <= pwdata[15:0];
				default: ;
			endcase
		end
	end
	assign prdata = (paddr[2] == REG_INV_TRACK) ? {16'd0, itw_q} : {16'd0, step_time_q};

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign fin_go   = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	// Sum and difference of the wheel speeds; the sum is twice the linear speed.
	assign v_old = 17'(ro_q) + 17'(lo_q);
	assign v_new = 17'(rn_q) + 17'(ln_q);
	assign d_old = 17'(ro_q) - 17'(lo_q);
	assign d_new = 17'(rn_q) - 17'(ln_q);

	// Rounding is half up: add half a unit of the dropped part, then shift with floor.
	assign r16   = (t_q + 64'sd32768) >>> 16;
	assign r17   = (t_q + 64'sd65536) >>> 17;
	assign r_th1 = (prod + 64'sd524288) >>> 20;
	assign r_pos = (prod + 64'sd134217728) >>> 28;
	assign r_h   = (prod + 64'sd34359738368) >>> 36;

	assign is_cord = (state_q == ST_COS0) || (state_q == ST_COS1);
	assign op_done = is_cord ? cord_done : mul_done;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_xfer) begin
				state_d = (func || itw_q == 16'd0) ? ST_FIN : ST_W_OLD;
			end
			ST_W_OLD: if (op_done) state_d = ST_W_NEW;
			ST_W_NEW: if (op_done) state_d = ST_P1;
			ST_P1:    if (op_done) state_d = ST_D1;
			ST_D1:    if (op_done) state_d = ST_COS0;
			ST_COS0:  if (op_done) state_d = ST_COS1;
			ST_COS1:  if (op_done) state_d = ST_MX0;
			ST_MX0:   if (op_done) state_d = ST_MX1;
			ST_MX1:   if (op_done) state_d = ST_MY0;
			ST_MY0:   if (op_done) state_d = ST_MY1;
			ST_MY1:   if (op_done) state_d = ST_DX;
			ST_DX:    if (op_done) state_d = ST_DY;
			ST_DY:    if (op_done) state_d = ST_HS;
			ST_HS:    if (op_done) state_d = ST_HD;
			ST_HD:    if (op_done) state_d = ST_FIN;
			ST_FIN:   if (fin_go) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Operand selection for the shared multiplier and the CORDIC; unsigned operands get a zero sign bit.
	always_comb begin
		mul_start  = 1'b0;
		cord_start = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		mul_n   = N_SHORT;
		cord_th = {h_q, 16'd0};
		unique case (state_q)
			ST_W_OLD: begin mul_a = 64'(d_old); mul_b = 35'(itw_q); end
			ST_W_NEW: begin mul_a = 64'(d_new); mul_b = 35'(itw_q); end
			ST_P1:    begin mul_a = 64'(w_old_q); mul_b = 35'(step_time_q); end
			ST_D1:    begin mul_a = r16; mul_b = 35'(TURN_PER_RAD); mul_n = N_TURN; end
			ST_COS1:  cord_th = th1_q;
			ST_MX0:   begin mul_a = 64'(c0_q); mul_b = 35'($unsigned(v_old)); end
			ST_MX1:   begin mul_a = 64'(c1_q); mul_b = 35'($unsigned(v_new)); end
			ST_MY0:   begin mul_a = 64'(s0_q); mul_b = 35'($unsigned(v_old)); end
			ST_MY1:   begin mul_a = 64'(s1_q); mul_b = 35'($unsigned(v_new)); end
			ST_DX:    begin mul_a = r16; mul_b = 35'(step_time_q); end
			ST_DY:    begin mul_a = r16; mul_b = 35'(step_time_q); end
			ST_HS:    begin
				mul_a = 64'(w_old_q) + 64'(w_new_q);
				mul_b = 35'(step_time_q);
			end
			ST_HD:    begin mul_a = r17; mul_b = 35'(TURN_PER_RAD); mul_n = N_TURN; end
			default: ;
		endcase
		if (state_q != ST_IDLE && state_q != ST_FIN && !issued_q) begin
			if (is_cord) cord_start = 1'b1;
			else         mul_start  = 1'b1;
		end
	end

	// The signed wheel products take 17 multiplier bits, so their sign bit is the top one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
			x_q         <= '0;
			y_q         <= '0;
			h_q         <= '0;
		end else begin
			state_q <= state_d;
			if (mul_start || cord_start) issued_q <= 1'b1;
			else if (op_done)            issued_q <= 1'b0;
			if (fin_go)                  out_valid_q <= 1'b1;
			else if (out_ready)          out_valid_q <= 1'b0;
			if (in_xfer && func) begin
				x_q <= load_x;
				y_q <= load_y;
				h_q <= load_heading;
			end
			if (op_done) begin
				unique case (state_q)
					ST_DX: x_q <= x_q + r_pos[31:0];
					ST_DY: y_q <= y_q + r_pos[31:0];
					ST_HD: h_q <= h_q + r_h[15:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ro_q  <= right_prev;
			lo_q  <= left_prev;
			rn_q  <= right_new;
			ln_q  <= left_new;
			err_q <= !func && (itw_q == 16'd0);
		end
		if (op_done) begin
			unique case (state_q)
				ST_W_OLD: w_old_q <= prod[33:0];
				ST_W_NEW: w_new_q <= prod[33:0];
				ST_P1:    t_q     <= prod;
				ST_D1:    th1_q   <= {h_q, 16'd0} + r_th1[31:0];
				ST_COS0:  begin c0_q <= cord_c; s0_q <= cord_s; end
				ST_COS1:  begin c1_q <= cord_c; s1_q <= cord_s; end
				ST_MX0:   sx_q <= prod;
				ST_MX1:   begin sx_q <= sx_q + prod; t_q <= sx_q + prod; end
				ST_MY0:   sy_q <= prod;
				ST_MY1:   sy_q <= sy_q + prod;
				ST_DX:    t_q  <= sy_q;
				ST_HS:    t_q  <= prod;
				default: ;
			endcase
		end
		if (fin_go) begin
			out_x_q   <= x_q;
			out_y_q   <= y_q;
			out_h_q   <= h_q;
			out_err_q <= err_q;
		end
	end

	ddoh_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.nbits  (mul_n),
		.done   (mul_done),
		.prod   (prod)
	);

	ddoh_cordic #(.ITERS(SINCOS_ITERATIONS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.theta  (cord_th),
		.done   (cord_done),
		.cos_o  (cord_c),
		.sin_o  (cord_s)
	);

	assign out_valid    = out_valid_q;
	assign out_x        = out_x_q;
	assign out_y        = out_y_q;
	assign out_heading  = out_h_q;
	assign config_error = out_err_q;

endmodule

FILE: src/ddoh_checker.sv
// Port-level checks of the odometry integrator, bound to its top level.
// Depends on diff_drive_odometry_heun's ports only.
module ddoh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_x,
	input logic        pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x))
		else $error("result changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transfer taken while an item is in work");

	a_no_wait: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("configuration port inserted a wait state");

endmodule

bind diff_drive_odometry_heun ddoh_checker u_ddoh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_x     (out_x),
	.pready    (pready)
);

FILE: tb/diff_drive_odometry_heun_test.sv
// Self-checking testbench of the differential-drive Heun odometry integrator.
// Depends on ddoh_pkg and diff_drive_odometry_heun; predicts each pose in fixed point.
`timescale 1ns / 1ps

module diff_drive_odometry_heun_test;
	import ddoh_pkg::*;

	localparam int CORDIC_STEPS = 16;
	localparam logic FUNC_STEP = 1'b0;
	localparam logic FUNC_LOAD = 1'b1;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic        [15:0] heading;
		logic               err;
	} pose_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic func = 1'b0;
	logic signed [15:0] right_prev = '0, left_prev = '0, right_new = '0, left_new = '0;
	logic signed [31:0] load_x = '0, load_y = '0;
	logic [15:0] load_heading = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] out_x, out_y;
	logic [15:0] out_heading;
	logic config_error;

	// Predictor state: registers and pose as the block should hold them.
	logic [15:0] dt_reg, itw_reg;
	logic [31:0] pose_x, pose_y;
	logic [15:0] pose_h;

	pose_t expected_poses[$];
	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int error_results = 0;
	longint cycles = 0;

	diff_drive_odometry_heun #(.SINCOS_ITERATIONS(CORDIC_STEPS)) i_dut (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[diff_drive_odometry_heun] ERROR");
			$finish;
		end
	end

	// Round half up: add half, then an arithmetic (floor) shift.
	function automatic longint rnd(input longint a, input int n);
		return (a + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	// Quadrant-folded CORDIC rotation; angle is a 32-bit turn fraction, results Q30.
	function automatic void rotate(input logic [31:0] th, output longint c, output longint s);
		logic [1:0] q;
		logic [31:0] ru;
		longint x, y, z, xs, ys;
		q = 2'((th + 32'h20000000) >> 30);
		ru = th - {q, 30'd0};
		z = longint'(signed'(ru));
		x = 652032874;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(atan_turn(5'(i)));
			end else begin
				x += ys; y -= xs; z += longint'(atan_turn(5'(i)));
			end
		end
		case (q)
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	// Advances the predicted pose by one item and queues the pose expected back.
	function automatic void advance_pose(input logic fn, input logic signed [15:0] ro, lo, rn, ln,
			input logic [31:0] lx, ly, input logic [15:0] lh);
		pose_t p;
		longint v0, v1, w0, w1, d1, c0, s0, c1, s1, dx, dy, dh;
		logic [31:0] th0, th1;
		p.err = 1'b0;
		if (fn == FUNC_LOAD) begin
			pose_x = lx; pose_y = ly; pose_h = lh;
		end else if (itw_reg == 0) begin
			p.err = 1'b1;
		end else begin
			v0 = longint'(ro) + longint'(lo);
			v1 = longint'(rn) + longint'(ln);
			w0 = (longint'(ro) - longint'(lo)) * longint'(itw_reg);
			w1 = (longint'(rn) - longint'(ln)) * longint'(itw_reg);
			th0 = {pose_h, 16'd0};
			d1 = rnd(rnd(w0 * longint'(dt_reg), 16) * 683565276, 20);
			th1 = th0 + 32'(d1);
			rotate(th0, c0, s0);
			rotate(th1, c1, s1);
			dx = rnd(rnd(v0 * c0 + v1 * c1, 16) * longint'(dt_reg), 28);
			dy = rnd(rnd(v0 * s0 + v1 * s1, 16) * longint'(dt_reg), 28);
			dh = rnd(rnd((w0 + w1) * longint'(dt_reg), 17) * 683565276, 36);
			pose_x = pose_x + 32'(dx);
			pose_y = pose_y + 32'(dy);
			pose_h = pose_h + 16'(dh);
		end
		p.x = pose_x; p.y = pose_y; p.heading = pose_h;
		expected_poses.push_back(p);
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch on %s at result %0d: got %0h, expected %0h", what, results_seen, got, want);
		mismatches++;
	endtask

	// Result side: random back-pressure per result, and a field-by-field check.
	initial begin
		int stall;
		pose_t e;
		forever begin
			stall = $urandom_range(0, 4);
			if (($urandom & 3) == 0) stall = 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			// A transfer on the output channel took place at this edge.
			results_seen++;
			if (expected_poses.size() == 0) begin
				report_mismatch("unexpected result", out_x, 0);
			end else begin
				e = expected_poses.pop_front();
				if (out_x !== e.x) report_mismatch("out_x", out_x, e.x);
				if (out_y !== e.y) report_mismatch("out_y", out_y, e.y);
				if (out_heading !== e.heading) report_mismatch("out_heading", out_heading, e.heading);
				if (config_error !== e.err) report_mismatch("config_error", config_error, e.err);
				if (e.err) error_results++;
			end
		end
	end

	// Register write over the configuration port: setup cycle, access cycle, then an idle cycle.
	task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == REG_STEP_TIME) dt_reg = value;
		else itw_reg = value;
		@(posedge clk);
	endtask

	// Sends one item after a random gap and predicts its result at the transfer.
	task automatic send_item(input logic fn, input logic signed [15:0] ro, lo, rn, ln,
			input logic [31:0] lx, ly, input logic [15:0] lh);
		int gap;
		gap = $urandom_range(0, 4);
		if (($urandom & 3) == 0) gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1; func <= fn;
		right_prev <= ro; left_prev <= lo; right_new <= rn; left_new <= ln;
		load_x <= lx; load_y <= ly; load_heading <= lh;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		advance_pose(fn, ro, lo, rn, ln, lx, ly, lh);
		items_sent++;
	endtask

	task automatic send_step(input logic signed [15:0] ro, lo, rn, ln);
		send_item(FUNC_STEP, ro, lo, rn, ln, $urandom, $urandom, 16'($urandom));
	endtask

	task automatic send_load(input logic [31:0] lx, ly, input logic [15:0] lh);
		send_item(FUNC_LOAD, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			lx, ly, lh);
	endtask

	// Drops valid, then waits until every queued pose has come back, plus a short pause.
	task automatic drain;
		in_valid <= 1'b0;
		while (expected_poses.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Integrate items while the reciprocal width is still zero must flag an error.
	task automatic test_unconfigured;
		send_step(16'sh1000, 16'sh0800, 16'sh7FFF, -16'sh8000);
		send_load(32'h0001_0000, 32'hFFFF_0000, 16'h4000);
		send_step(16'sh1000, 16'sh1000, 16'sh1000, 16'sh1000);
		drain();
	endtask

	// Field extremes, heading wrap, position overflow and zero wheel speeds.
	task automatic test_directed;
		write_reg(REG_STEP_TIME, 16'hFFFF);
		write_reg(REG_INV_TRACK, 16'hFFFF);
		send_step(16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh7FFF);
		send_step(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
		send_step(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_load(32'h7FFF_FFF0, 32'h8000_0010, 16'hFFFF);
		send_step(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_step(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
		send_load(32'h8000_0000, 32'h7FFF_FFFF, 16'h0000);
		send_step(16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000);
		send_load(32'hFFFF_FFFF, 32'h0, 16'h8000);
		for (int q = 0; q < 4; q++) begin
			send_load(32'h0, 32'h0, 16'(q * 16'h4000 + 16'h2000));
			send_step(16'sh2000, 16'sh1000, 16'sh2000, 16'sh1000);
		end
		drain();
		write_reg(REG_STEP_TIME, 16'h0001);
		write_reg(REG_INV_TRACK, 16'h0001);
		send_step(16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000);
		send_step(16'sh1234, -16'sh4321, 16'sh0001, 16'sh0000);
		drain();
	endtask

	// Random phases: mostly integrate runs with occasional loads, over several settings.
	task automatic test_random(input int count, input logic [15:0] dt, input logic [15:0] itw);
		write_reg(REG_STEP_TIME, dt);
		write_reg(REG_INV_TRACK, itw);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 15) == 0)
				send_load($urandom, $urandom, 16'($urandom));
			else if ($urandom_range(0, 3) == 0)
				send_step(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			else
				send_step(16'(int'($urandom_range(0, 8192)) - 4096),
					16'(int'($urandom_range(0, 8192)) - 4096),
					16'(int'($urandom_range(0, 8192)) - 4096),
					16'(int'($urandom_range(0, 8192)) - 4096));
			// Once, halfway through the phase, hold the sender off until every pose has come back.
			if (n == count / 2) drain();
		end
		drain();
	endtask

	initial begin
		dt_reg = 16'd655; itw_reg = 16'd0;
		pose_x = '0; pose_y = '0; pose_h = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unconfigured();
		test_directed();
		test_random(200, 16'd655, 16'd512);
		test_random(200, 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
		test_random(200, 16'hFFFF, 16'hFFFF);
		test_random(150, 16'd0, 16'd256);
		test_random(150, 16'd3000, 16'd0);
		test_random(150, 16'($urandom_range(1, 4000)), 16'($urandom_range(1, 2000)));
		drain();
		$display("Sent %0d items over nine register settings; %0d results checked, %0d flagged.",
			items_sent, results_seen, error_results);
		if (mismatches == 0) begin
			$display("[diff_drive_odometry_heun] OK");
		end else begin
			$display("[diff_drive_odometry_heun] ERROR");
		end
		$finish;
	end

endmodule
